// ===== rtl/luhn_card_number_check_assert.svh =====
// assertion macros used by the checker file luhn_check.sv
`ifndef LUHN_CARD_NUMBER_CHECK_ASSERT_SVH
`define LUHN_CARD_NUMBER_CHECK_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LUHN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LUHN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/luhn_pkg.sv =====
`default_nettype none

package luhn_pkg;

    // field widths
    localparam int IN_W      = 63;
    localparam int VERDICT_W = 2;
    localparam int COUNT_W   = 5;
    localparam int PAIR_W    = 7;
    localparam int DIGIT_W   = 4;

    // number of digit slots processed
    localparam int MAX_DIGITS = 19;

    // binary to bcd conversion: 19 digits hold any 63-bit value
    localparam int BCD_DIGITS = 19;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int STEP_BITS  = 7;
    localparam int CONV_STEPS = IN_W / STEP_BITS;
    localparam int STEP_CNT_W = $clog2(CONV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_DIGITS,
        ST_FINISH
    } state_t;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_INVALID   = 2'd0,
        VERDICT_PREFIX_3X = 2'd1,
        VERDICT_PREFIX_5X = 2'd2,
        VERDICT_PREFIX_4X = 2'd3
    } verdict_t;

    // commands to the conversion unit
    typedef struct packed {
        logic load;
        logic convert;
        logic shift;
    } conv_cmd_t;

    // status from the conversion unit
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               rest_zero;
    } conv_stat_t;

    // commands to the digit accumulator
    typedef struct packed {
        logic clear;
        logic take;
    } acc_cmd_t;

    // status from the digit accumulator
    typedef struct packed {
        logic [DIGIT_W-1:0] sum_mod10;
        logic [COUNT_W-1:0] count;
        logic [PAIR_W-1:0]  pair;
    } acc_stat_t;

    // issuer class from leading pair and digit count
    function automatic verdict_t classify(logic [PAIR_W-1:0] pair, logic [COUNT_W-1:0] count);
        verdict_t v;
        v = VERDICT_INVALID;
        if ((pair inside {7'd34, 7'd37}) && count == 5'd15)
        begin
            v = VERDICT_PREFIX_3X;
        end
        else if ((pair inside {[7'd51:7'd55]}) && count == 5'd16)
        begin
            v = VERDICT_PREFIX_5X;
        end
        else if ((pair inside {[7'd40:7'd49]}) && (count inside {5'd13, 5'd16}))
        begin
            v = VERDICT_PREFIX_4X;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/luhn_in_if.sv =====
`default_nettype none

interface luhn_in_if;
    logic                      valid;
    logic                      ready;
    logic [luhn_pkg::IN_W-1:0] card_number;

    modport source (output valid, output card_number, input ready);
    modport sink (input valid, input card_number, output ready);
endinterface

`default_nettype wire

// ===== rtl/luhn_out_if.sv =====
`default_nettype none

interface luhn_out_if;
    logic                           valid;
    logic                           ready;
    logic [luhn_pkg::VERDICT_W-1:0] verdict;
    logic                           checksum_ok;
    logic [luhn_pkg::COUNT_W-1:0]   digit_count;
    logic [luhn_pkg::PAIR_W-1:0]    leading_pair;

    modport source (output valid, output verdict, output checksum_ok,
                    output digit_count, output leading_pair, input ready);
    modport sink (input valid, input verdict, input checksum_ok,
                  input digit_count, input leading_pair, output ready);
endinterface

`default_nettype wire

// ===== rtl/luhn_card_number_check.sv =====
// Luhn mod-10 card number checker.
// Input channel card: one word is a 63-bit unsigned card number, accepted
// when valid and ready are both high. Output channel result: one word per
// input with verdict, checksum_ok, digit_count and leading_pair.
// Each number first passes a binary to bcd conversion, 7 bits per cycle;
// then one digit a cycle goes through the digit accumulator, and a
// classify step loads the output register. One number is in work at a
// time: ready is high only while idle.
// The output register holds its word until the receiver takes it; a held
// result does not block the next number, but a finished second result
// waits in the classify step until the register frees up.
// Reset (rst_n low, asynchronous) returns to idle and drops result valid.
`default_nettype none

module luhn_card_number_check (
    input  wire logic   clk,
    input  wire logic   rst_n,
    luhn_in_if.sink     card,
    luhn_out_if.source  result
);

    luhn_pkg::state_t                   state_reg;
    luhn_pkg::state_t                   state_next;
    logic [luhn_pkg::STEP_CNT_W-1:0]    step_reg;
    logic [luhn_pkg::STEP_CNT_W-1:0]    step_next;
    logic                               too_long_reg;
    logic                               too_long_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [luhn_pkg::VERDICT_W-1:0]     verdict_reg;
    logic [luhn_pkg::VERDICT_W-1:0]     verdict_next;
    logic                               ok_reg;
    logic                               ok_next;
    logic [luhn_pkg::COUNT_W-1:0]       count_reg;
    logic [luhn_pkg::COUNT_W-1:0]       count_next;
    logic [luhn_pkg::PAIR_W-1:0]        pair_reg;
    logic [luhn_pkg::PAIR_W-1:0]        pair_next;

    luhn_pkg::conv_cmd_t                conv_cmd;
    luhn_pkg::conv_stat_t               conv_stat;
    luhn_pkg::acc_cmd_t                 acc_cmd;
    luhn_pkg::acc_stat_t                acc_stat;
    logic                               sum_ok;

    luhn_bcd_conv u_conv (
        .clk    (clk),
        .cmd    (conv_cmd),
        .number (card.card_number),
        .stat   (conv_stat)
    );

    luhn_digit_acc u_acc (
        .clk   (clk),
        .cmd   (acc_cmd),
        .digit (conv_stat.digit),
        .stat  (acc_stat)
    );

    assign sum_ok = (acc_stat.sum_mod10 == '0);

    // sequencer: next state and unit commands
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        too_long_next  = too_long_reg;
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        ok_next        = ok_reg;
        count_next     = count_reg;
        pair_next      = pair_reg;
        conv_cmd       = '0;
        acc_cmd        = '0;

        // receiver takes the held word
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            luhn_pkg::ST_IDLE:
            begin
                if (card.valid)
                begin
                    conv_cmd.load = 1'b1;
                    acc_cmd.clear = 1'b1;
                    step_next     = '0;
                    state_next    = luhn_pkg::ST_CONV;
                end
            end
            luhn_pkg::ST_CONV:
            begin
                conv_cmd.convert = 1'b1;
                step_next        = step_reg + 1'b1;
                if (step_reg == luhn_pkg::STEP_CNT_W'(luhn_pkg::CONV_STEPS - 1))
                begin
                    state_next = luhn_pkg::ST_DIGITS;
                end
            end
            luhn_pkg::ST_DIGITS:
            begin
                conv_cmd.shift = 1'b1;
                acc_cmd.take   = 1'b1;
                if (conv_stat.rest_zero ||
                    acc_stat.count == luhn_pkg::COUNT_W'(luhn_pkg::MAX_DIGITS - 1))
                begin
                    too_long_next = !conv_stat.rest_zero;
                    state_next    = luhn_pkg::ST_FINISH;
                end
            end
            luhn_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = sum_ok;
                    count_next     = acc_stat.count;
                    pair_next      = acc_stat.pair;
                    verdict_next   = (sum_ok && !too_long_reg)
                                   ? luhn_pkg::classify(acc_stat.pair, acc_stat.count)
                                   : luhn_pkg::VERDICT_INVALID;
                    state_next     = luhn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = luhn_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= luhn_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sequencing and payload registers
    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        too_long_reg <= too_long_next;
        verdict_reg  <= verdict_next;
        ok_reg       <= ok_next;
        count_reg    <= count_next;
        pair_reg     <= pair_next;
    end

    assign card.ready          = (state_reg == luhn_pkg::ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.verdict      = verdict_reg;
    assign result.checksum_ok  = ok_reg;
    assign result.digit_count  = count_reg;
    assign result.leading_pair = pair_reg;

endmodule

`default_nettype wire

// ===== rtl/luhn_bcd_conv.sv =====
`default_nettype none

module luhn_bcd_conv (
    input  wire logic                      clk,
    input  wire luhn_pkg::conv_cmd_t       cmd,
    input  wire logic [luhn_pkg::IN_W-1:0] number,
    output luhn_pkg::conv_stat_t           stat
);

    logic [luhn_pkg::IN_W-1:0]  bin_reg;
    logic [luhn_pkg::IN_W-1:0]  bin_next;
    logic [luhn_pkg::BCD_W-1:0] bcd_reg;
    logic [luhn_pkg::BCD_W-1:0] bcd_next;

    // shift-add-3 over one group of input bits, msb first
    function automatic logic [luhn_pkg::BCD_W+luhn_pkg::IN_W-1:0] dabble(
        logic [luhn_pkg::BCD_W-1:0] b_in, logic [luhn_pkg::IN_W-1:0] s_in);
        logic [luhn_pkg::BCD_W-1:0] b;
        logic [luhn_pkg::IN_W-1:0]  s;
        b = b_in;
        s = s_in;
        for (int k = 0; k < luhn_pkg::STEP_BITS; k++)
        begin
            for (int i = 0; i < luhn_pkg::BCD_DIGITS; i++)
            begin
                if (b[i*luhn_pkg::DIGIT_W +: luhn_pkg::DIGIT_W] >= 4'd5)
                begin
                    b[i*luhn_pkg::DIGIT_W +: luhn_pkg::DIGIT_W] =
                        b[i*luhn_pkg::DIGIT_W +: luhn_pkg::DIGIT_W] + 4'd3;
                end
            end
            b = {b[luhn_pkg::BCD_W-2:0], s[luhn_pkg::IN_W-1]};
            s = {s[luhn_pkg::IN_W-2:0], 1'b0};
        end
        return {b, s};
    endfunction

    // next value of the binary and bcd registers
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        if (cmd.load)
        begin
            bin_next = number;
            bcd_next = '0;
        end
        else if (cmd.convert)
        begin
            {bcd_next, bin_next} = dabble(bcd_reg, bin_reg);
        end
        else if (cmd.shift)
        begin
            bcd_next = {{luhn_pkg::DIGIT_W{1'b0}}, bcd_reg[luhn_pkg::BCD_W-1:luhn_pkg::DIGIT_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // lowest digit and whether anything remains above it
    assign stat.digit     = bcd_reg[luhn_pkg::DIGIT_W-1:0];
    assign stat.rest_zero = (bcd_reg[luhn_pkg::BCD_W-1:luhn_pkg::DIGIT_W] == '0);

endmodule

`default_nettype wire

// ===== rtl/luhn_digit_acc.sv =====
`default_nettype none

module luhn_digit_acc (
    input  wire logic                         clk,
    input  wire luhn_pkg::acc_cmd_t           cmd,
    input  wire logic [luhn_pkg::DIGIT_W-1:0] digit,
    output luhn_pkg::acc_stat_t               stat
);

    logic [luhn_pkg::DIGIT_W-1:0] sum_reg;
    logic [luhn_pkg::DIGIT_W-1:0] sum_next;
    logic [luhn_pkg::COUNT_W-1:0] count_reg;
    logic [luhn_pkg::COUNT_W-1:0] count_next;
    logic [luhn_pkg::PAIR_W-1:0]  pair_reg;
    logic [luhn_pkg::PAIR_W-1:0]  pair_next;
    logic [luhn_pkg::DIGIT_W-1:0] top_reg;
    logic [luhn_pkg::DIGIT_W-1:0] top_next;
    logic [luhn_pkg::DIGIT_W-1:0] term;
    logic [luhn_pkg::DIGIT_W:0]   dbl;
    logic [luhn_pkg::DIGIT_W:0]   raw_sum;
    logic [luhn_pkg::PAIR_W-1:0]  times_ten;

    // doubled digit folded back to one digit, odd slots only
    always_comb
    begin
        dbl  = {digit, 1'b0};
        term = digit;
        if (count_reg[0])
        begin
            term = (dbl >= 5'd10) ? luhn_pkg::DIGIT_W'(dbl - 5'd9) : dbl[luhn_pkg::DIGIT_W-1:0];
        end
    end

    // running total kept modulo ten
    assign raw_sum   = {1'b0, sum_reg} + {1'b0, term};
    assign times_ten = {digit, 3'b000} + {2'b00, digit, 1'b0};

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        pair_next  = pair_reg;
        top_next   = top_reg;
        if (cmd.clear)
        begin
            sum_next   = '0;
            count_next = '0;
            pair_next  = '0;
            top_next   = '0;
        end
        else if (cmd.take)
        begin
            sum_next   = (raw_sum >= 5'd10) ? luhn_pkg::DIGIT_W'(raw_sum - 5'd10)
                                            : raw_sum[luhn_pkg::DIGIT_W-1:0];
            count_next = count_reg + 1'b1;
            pair_next  = (count_reg == '0) ? {3'b000, digit}
                                           : times_ten + {3'b000, top_reg};
            top_next   = digit;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        count_reg <= count_next;
        pair_reg  <= pair_next;
        top_reg   <= top_next;
    end

    assign stat.sum_mod10 = sum_reg;
    assign stat.count     = count_reg;
    assign stat.pair      = pair_reg;

endmodule

`default_nettype wire

// ===== rtl/luhn_check.sv =====
`default_nettype none

`include "luhn_card_number_check_assert.svh"

module luhn_check (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [luhn_pkg::VERDICT_W-1:0] verdict,
    input wire logic                           checksum_ok,
    input wire logic [luhn_pkg::COUNT_W-1:0]   digit_count,
    input wire logic [luhn_pkg::PAIR_W-1:0]    leading_pair
);

    logic                                                         out_stall;
    logic [luhn_pkg::VERDICT_W+luhn_pkg::COUNT_W+luhn_pkg::PAIR_W:0] out_word;
    logic                                                         has_class;
    logic                                                         is_3x;
    logic                                                         shape_3x;

    // result word as one vector, and class shape terms
    assign out_stall = out_valid && !out_ready;
    assign out_word  = {verdict, checksum_ok, digit_count, leading_pair};
    assign has_class = out_valid && (verdict != luhn_pkg::VERDICT_INVALID);
    assign is_3x     = out_valid && (verdict == luhn_pkg::VERDICT_PREFIX_3X);
    assign shape_3x  = (digit_count == 5'd15) && (leading_pair == 7'd34 || leading_pair == 7'd37);

    // busy right after taking a word
    `LUHN_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

    // stalled result holds
    `LUHN_ASSERT_NEXT(a_result_holds, out_stall, out_valid && $stable(out_word), "result changed")

    // any class needs a good checksum
    `LUHN_ASSERT_NOW(a_class_needs_sum, has_class, checksum_ok, "class without checksum")

    // first class matches its prefix and length
    `LUHN_ASSERT_NOW(a_class_one_shape, is_3x, shape_3x, "bad first class")

endmodule

bind luhn_card_number_check luhn_check u_luhn_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (card.valid),
    .in_ready     (card.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .verdict      (result.verdict),
    .checksum_ok  (result.checksum_ok),
    .digit_count  (result.digit_count),
    .leading_pair (result.leading_pair)
);

`default_nettype wire
